// ----- rtl/heatmap_peak_subpixel_decode_macros.svh -----
// Assertion macros used by the checker file of the heatmap peak decoder.
`ifndef HEATMAP_PEAK_SUBPIXEL_DECODE_MACROS_SVH
`define HEATMAP_PEAK_SUBPIXEL_DECODE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPSD_CHECK_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPSD_CHECK_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpsd_pkg.sv -----
package hpsd_pkg;

    localparam int SCORE_W     = 8;
    localparam int POS_W       = 12;
    localparam int FIX_W       = 32;
    localparam int ROW_CFG_W   = 9;
    localparam int SHIFT_CFG_W = 5;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;
    // A 3x3 window of weights up to 255 sums to less than 4096.
    localparam int TOT_W       = 12;
    localparam int FRAC_W      = 16;
    localparam int STRIDE_LOG2 = 2;

    localparam logic [FIX_W-1:0]          HALF_PIXEL       = 32'd32768;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX        = 8'sd127;
    localparam logic [ROW_CFG_W-1:0]      ROW_WIDTH_RST    = 9'd64;
    localparam logic [SHIFT_CFG_W-1:0]    OFFSET_SHIFT_RST = 5'd0;
    localparam logic [SHIFT_CFG_W-1:0]    MAX_OFFSET_SHIFT = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SHIFT = 1'd1;

    typedef enum logic [1:0] {
        DIV_INDEX = 2'd0,
        DIV_COUNT = 2'd1,
        DIV_X     = 2'd2,
        DIV_Y     = 2'd3
    } div_op_t;

    typedef enum logic {
        PASS_MIN = 1'b0,
        PASS_SUM = 1'b1
    } scan_pass_t;

    typedef struct packed {
        logic       pix_take;
        logic       div_start;
        div_op_t    div_op;
        logic       scan_start;
        scan_pass_t scan_pass;
        logic       emit;
    } hpsd_cmd_t;

    typedef struct packed {
        logic last_accept;
        logic div_done;
        logic scan_done;
        logic slot_free;
    } hpsd_stat_t;

endpackage

// ----- rtl/hpsd_ifs.sv -----
interface hpsd_pix_if;
    import hpsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] peak_score;
    logic signed [SCORE_W-1:0] offset_x;
    logic signed [SCORE_W-1:0] offset_y;
    logic                      last_pixel;

    modport source (output valid, peak_score, offset_x, offset_y, last_pixel, input ready);
    modport sink (input valid, peak_score, offset_x, offset_y, last_pixel, output ready);
endinterface

interface hpsd_res_if;
    import hpsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [POS_W-1:0]          best_position;
    logic signed [SCORE_W-1:0] best_value;
    logic signed [FIX_W-1:0]   x_fixed;
    logic signed [FIX_W-1:0]   y_fixed;

    modport source (output valid, best_position, best_value, x_fixed, y_fixed, input ready);
    modport sink (input valid, best_position, best_value, x_fixed, y_fixed, output ready);
endinterface

interface hpsd_cfg_if;
    import hpsd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/hpsd_div.sv -----
module hpsd_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle, numerator shifted out MSB first.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/hpsd_ctrl.sv -----
module hpsd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  hpsd_pkg::hpsd_stat_t stat,
    output hpsd_pkg::hpsd_cmd_t  cmd
);
    import hpsd_pkg::*;

    typedef enum logic [7:0] {
        ST_LOAD     = 8'b0000_0001,
        ST_DIV_IDX  = 8'b0000_0010,
        ST_DIV_CNT  = 8'b0000_0100,
        ST_SCAN_MIN = 8'b0000_1000,
        ST_SCAN_SUM = 8'b0001_0000,
        ST_DIV_X    = 8'b0010_0000,
        ST_DIV_Y    = 8'b0100_0000,
        ST_EMIT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   launch_reg, launch_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (stat.last_accept)
                    state_next = ST_DIV_IDX;
            end
            ST_DIV_IDX:
            begin
                if (stat.div_done)
                    state_next = ST_DIV_CNT;
            end
            ST_DIV_CNT:
            begin
                if (stat.div_done)
                    state_next = ST_SCAN_MIN;
            end
            ST_SCAN_MIN:
            begin
                if (stat.scan_done)
                    state_next = ST_SCAN_SUM;
            end
            ST_SCAN_SUM:
            begin
                if (stat.scan_done)
                    state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (stat.div_done)
                    state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (stat.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Each work state kicks off its unit in its first cycle, so operands already
    // reflect the edge that entered the state.
    assign launch_next = (state_next != state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    always_comb
    begin
        cmd.pix_take   = (state_reg == ST_LOAD);
        cmd.div_start  = launch_reg && (state_reg == ST_DIV_IDX || state_reg == ST_DIV_CNT ||
                                        state_reg == ST_DIV_X || state_reg == ST_DIV_Y);
        cmd.scan_start = launch_reg && (state_reg == ST_SCAN_MIN || state_reg == ST_SCAN_SUM);
        cmd.scan_pass  = (state_reg == ST_SCAN_SUM) ? PASS_SUM : PASS_MIN;
        cmd.emit       = (state_reg == ST_EMIT) && stat.slot_free;
        case (state_reg)
            ST_DIV_CNT: cmd.div_op = DIV_COUNT;
            ST_DIV_X:   cmd.div_op = DIV_X;
            ST_DIV_Y:   cmd.div_op = DIV_Y;
            default:    cmd.div_op = DIV_INDEX;
        endcase
    end

endmodule

// ----- rtl/hpsd_dp.sv -----
module hpsd_dp #(
    parameter int MAX_PIXELS = 4096,
    parameter int MAX_WIDTH  = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hpsd_pix_if.sink             pixel,
    hpsd_res_if.source           result,
    hpsd_cfg_if.sink             cfg,
    input  hpsd_pkg::hpsd_cmd_t  cmd,
    output hpsd_pkg::hpsd_stat_t stat
);
    import hpsd_pkg::*;

    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int X_W   = $clog2(MAX_WIDTH);
    localparam int ADR_W = IDX_W + 2;
    localparam int SUM_W = TOT_W + IDX_W;
    localparam int NUM_W = SUM_W + FRAC_W;
    localparam int DEN_W = (TOT_W > WID_W) ? TOT_W : WID_W;
    localparam int PX_W  = SCORE_W + X_W;
    localparam int PY_W  = SCORE_W + IDX_W;

    // Configuration registers.
    logic [ROW_CFG_W-1:0]   row_width_reg;
    logic [SHIFT_CFG_W-1:0] offset_shift_reg;
    logic [WID_W-1:0]       w_eff;

    // Frame state.
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          peak_idx_reg;
    logic signed [SCORE_W-1:0] peak_val_reg;
    logic signed [SCORE_W-1:0] peak_ox_reg;
    logic signed [SCORE_W-1:0] peak_oy_reg;
    logic                      pix_acc;
    logic                      store_ok;

    logic signed [SCORE_W-1:0] mem [MAX_PIXELS];
    logic signed [SCORE_W-1:0] mem_q;
    logic [IDX_W-1:0]          rd_addr;

    // Decode results.
    logic [X_W-1:0]   cx_reg;
    logic [IDX_W-1:0] cy_reg;
    logic [CNT_W-1:0] height_reg;
    logic [FIX_W-1:0] qx_reg;
    logic [FIX_W-1:0] qy_reg;

    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [DEN_W-1:0] div_rem;

    // Window scan.
    logic [X_W-1:0]   x0, x1;
    logic [IDX_W-1:0] y0, y1;
    logic [ADR_W-1:0] base0;
    logic             sc_run_reg;
    logic [X_W-1:0]   sc_x_reg;
    logic [IDX_W-1:0] sc_y_reg;
    logic [ADR_W-1:0] sc_base_reg;
    logic [ADR_W-1:0] sc_idx;
    logic             sc_ok;
    logic             sc_last;

    logic             s1_vld_reg;
    logic             s1_ok_reg;
    logic             s1_last_reg;
    logic [X_W-1:0]   s1_x_reg;
    logic [IDX_W-1:0] s1_y_reg;
    logic [SCORE_W:0] diff9;
    logic [SCORE_W-1:0] wt;

    logic               s2_vld_reg;
    logic               s2_last_reg;
    logic [SCORE_W-1:0] wt_reg;
    logic [PX_W-1:0]    px_reg;
    logic [PY_W-1:0]    py_reg;

    logic signed [SCORE_W-1:0] min_reg;
    logic [TOT_W-1:0]          tot_reg;
    logic [SUM_W-1:0]          sx_reg;
    logic [SUM_W-1:0]          sy_reg;

    // Output register.
    logic                      res_valid_reg;
    logic [POS_W-1:0]          res_pos_reg;
    logic signed [SCORE_W-1:0] res_val_reg;
    logic signed [FIX_W-1:0]   res_x_reg;
    logic signed [FIX_W-1:0]   res_y_reg;

    function automatic logic [FIX_W-1:0] refine(
        input logic [FIX_W-1:0]          q,
        input logic signed [SCORE_W-1:0] off,
        input logic [SHIFT_CFG_W-1:0]    sh
    );
        logic signed [FIX_W-1:0] term;
        logic [FIX_W-1:0]        sum;
        if (sh > MAX_OFFSET_SHIFT)
            term = '0;
        else
            term = FIX_W'(off) <<< (MAX_OFFSET_SHIFT - sh);
        sum = q + HALF_PIXEL + term;
        return sum << STRIDE_LOG2;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= ROW_WIDTH_RST;
            offset_shift_reg <= OFFSET_SHIFT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ROW_WIDTH:    row_width_reg    <= cfg.data[ROW_CFG_W-1:0];
                REG_OFFSET_SHIFT: offset_shift_reg <= cfg.data[SHIFT_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // A width of zero counts as one; wider than the build limit saturates.
    always_comb
    begin
        if (row_width_reg == '0)
            w_eff = WID_W'(1);
        else if (32'(row_width_reg) > 32'(MAX_WIDTH))
            w_eff = WID_W'(MAX_WIDTH);
        else
            w_eff = WID_W'(row_width_reg);
    end

    // ------------------------------------------------------------------
    // Frame loading
    // ------------------------------------------------------------------
    assign pixel.ready = cmd.pix_take;
    assign pix_acc     = pixel.valid && cmd.pix_take;
    assign store_ok    = (count_reg < CNT_W'(MAX_PIXELS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            peak_idx_reg <= '0;
            peak_val_reg <= '0;
            peak_ox_reg  <= '0;
            peak_oy_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            count_reg    <= '0;
            peak_idx_reg <= '0;
            peak_val_reg <= '0;
            peak_ox_reg  <= '0;
            peak_oy_reg  <= '0;
        end
        else if (pix_acc && store_ok)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == '0 || pixel.peak_score > peak_val_reg)
            begin
                peak_idx_reg <= count_reg[IDX_W-1:0];
                peak_val_reg <= pixel.peak_score;
                peak_ox_reg  <= pixel.offset_x;
                peak_oy_reg  <= pixel.offset_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc && store_ok)
            mem[count_reg[IDX_W-1:0]] <= pixel.peak_score;
        mem_q <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Shared divider: peak row/column, frame height, and both centroids
    // ------------------------------------------------------------------
    always_comb
    begin
        case (cmd.div_op)
            DIV_INDEX:
            begin
                div_num = NUM_W'(peak_idx_reg);
                div_den = DEN_W'(w_eff);
            end
            DIV_COUNT:
            begin
                div_num = NUM_W'(count_reg);
                div_den = DEN_W'(w_eff);
            end
            DIV_X:
            begin
                if (tot_reg == '0)
                begin
                    div_num = NUM_W'(cx_reg) << FRAC_W;
                    div_den = DEN_W'(1);
                end
                else
                begin
                    div_num = {sx_reg, {FRAC_W{1'b0}}} + NUM_W'(tot_reg >> 1);
                    div_den = DEN_W'(tot_reg);
                end
            end
            DIV_Y:
            begin
                if (tot_reg == '0)
                begin
                    div_num = NUM_W'(cy_reg) << FRAC_W;
                    div_den = DEN_W'(1);
                end
                else
                begin
                    div_num = {sy_reg, {FRAC_W{1'b0}}} + NUM_W'(tot_reg >> 1);
                    div_den = DEN_W'(tot_reg);
                end
            end
            default:
            begin
                div_num = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    hpsd_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_quo),
        .rem  (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (cmd.div_op)
                DIV_INDEX:
                begin
                    cy_reg <= IDX_W'(div_quo);
                    cx_reg <= X_W'(div_rem);
                end
                DIV_COUNT: height_reg <= CNT_W'(div_quo);
                DIV_X:     qx_reg     <= FIX_W'(div_quo);
                DIV_Y:     qy_reg     <= FIX_W'(div_quo);
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window scan, clipped at the frame edges
    // ------------------------------------------------------------------
    always_comb
    begin
        x0 = (cx_reg == '0) ? '0 : cx_reg - 1'b1;
        x1 = (32'(cx_reg) + 32'd1 < 32'(w_eff)) ? cx_reg + 1'b1 : cx_reg;
        y0 = (cy_reg == '0) ? '0 : cy_reg - 1'b1;
        y1 = (32'(cy_reg) + 32'd1 < 32'(height_reg)) ? cy_reg + 1'b1 : cy_reg;
        // Start of the top window row, derived from the peak index without a multiply.
        base0 = ADR_W'(peak_idx_reg) - ADR_W'(cx_reg)
              - ((cy_reg != '0) ? ADR_W'(w_eff) : '0);
    end

    assign sc_idx  = sc_base_reg + ADR_W'(sc_x_reg);
    assign sc_ok   = (sc_idx < ADR_W'(count_reg));
    assign sc_last = (sc_x_reg == x1) && (sc_y_reg == y1);
    assign rd_addr = sc_idx[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_run_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
                sc_run_reg <= 1'b1;
            else if (sc_run_reg && sc_last)
                sc_run_reg <= 1'b0;
            s1_vld_reg <= sc_run_reg;
            s2_vld_reg <= s1_vld_reg && (cmd.scan_pass == PASS_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            sc_x_reg    <= x0;
            sc_y_reg    <= y0;
            sc_base_reg <= base0;
        end
        else if (sc_run_reg && sc_x_reg == x1)
        begin
            sc_x_reg    <= x0;
            sc_y_reg    <= sc_y_reg + 1'b1;
            sc_base_reg <= sc_base_reg + ADR_W'(w_eff);
        end
        else if (sc_run_reg)
        begin
            sc_x_reg <= sc_x_reg + 1'b1;
        end
        s1_ok_reg   <= sc_ok;
        s1_last_reg <= sc_last;
        s1_x_reg    <= sc_x_reg;
        s1_y_reg    <= sc_y_reg;
    end

    // Weights are never negative: the minimum covers every cell counted.
    assign diff9 = {mem_q[SCORE_W-1], mem_q} - {min_reg[SCORE_W-1], min_reg};
    assign wt    = s1_ok_reg ? diff9[SCORE_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        s2_last_reg <= s1_last_reg;
        wt_reg      <= wt;
        px_reg      <= PX_W'(wt) * PX_W'(s1_x_reg);
        py_reg      <= PY_W'(wt) * PY_W'(s1_y_reg);

        if (cmd.scan_start && cmd.scan_pass == PASS_MIN)
            min_reg <= SCORE_MAX;
        else if (s1_vld_reg && s1_ok_reg && cmd.scan_pass == PASS_MIN && mem_q < min_reg)
            min_reg <= mem_q;

        if (cmd.scan_start && cmd.scan_pass == PASS_SUM)
        begin
            tot_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
        end
        else if (s2_vld_reg)
        begin
            tot_reg <= tot_reg + TOT_W'(wt_reg);
            sx_reg  <= sx_reg + SUM_W'(px_reg);
            sy_reg  <= sy_reg + SUM_W'(py_reg);
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.emit)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_pos_reg <= POS_W'(peak_idx_reg);
            res_val_reg <= peak_val_reg;
            res_x_reg   <= $signed(refine(qx_reg, peak_ox_reg, offset_shift_reg));
            res_y_reg   <= $signed(refine(qy_reg, peak_oy_reg, offset_shift_reg));
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.best_position = res_pos_reg;
    assign result.best_value    = res_val_reg;
    assign result.x_fixed       = res_x_reg;
    assign result.y_fixed       = res_y_reg;

    always_comb
    begin
        stat.last_accept = pix_acc && pixel.last_pixel;
        stat.div_done    = div_done;
        stat.scan_done   = (cmd.scan_pass == PASS_MIN) ? (s1_vld_reg && s1_last_reg)
                                                       : (s2_vld_reg && s2_last_reg);
        stat.slot_free   = !res_valid_reg || result.ready;
    end

endmodule

// ----- rtl/heatmap_peak_subpixel_decode.sv -----
// Heatmap peak decoder with sub-pixel refinement. Pixels arrive on the pixel
// channel in raster order, one per cycle while loading; the pixel marked last
// ends the frame and starts the decode, during which pixel ready stays low.
// The decode runs four divisions on one shared restoring divider of
// NUM_W = 28 + log2(MAX_PIXELS) bits and two passes of at most nine reads
// over the score memory, and may then wait for the output register to be taken.
// The result sits in an output register, so loading of the next frame starts
// while it waits to be taken. Row width and offset shift must be written
// through the configuration channel between frames; the block itself does not
// enforce this. The score memory needs no clearing after reset.
module heatmap_peak_subpixel_decode #(
    parameter int MAX_PIXELS = 4096,
    parameter int MAX_WIDTH  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    hpsd_pix_if.sink   pixel,
    hpsd_res_if.source result,
    hpsd_cfg_if.sink   cfg
);
    import hpsd_pkg::*;

    hpsd_cmd_t  cmd;
    hpsd_stat_t stat;

    hpsd_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .cmd  (cmd)
    );

    hpsd_dp #(
        .MAX_PIXELS(MAX_PIXELS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel),
        .result(result),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ----- rtl/hpsd_chk.sv -----
`include "heatmap_peak_subpixel_decode_macros.svh"

module hpsd_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input logic                          pix_last,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [hpsd_pkg::FIX_W-1:0]    x_fixed,
    input logic [hpsd_pkg::FIX_W-1:0]    y_fixed
);
    import hpsd_pkg::*;

    // A pending result is held until the sink takes it.
    `HPSD_CHECK_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped")

    // The last pixel of a frame closes the input for the decode.
    `HPSD_CHECK_NEXT(a_last_stalls, clk, rst_n, pix_valid && pix_ready && pix_last, !pix_ready, "input open after last pixel")

    // Positions are scaled by the stride, so the two low bits are always clear.
    `HPSD_CHECK_NOW(a_stride_align, clk, rst_n, res_valid, (x_fixed[1:0] == 2'b00) && (y_fixed[1:0] == 2'b00), "position not stride aligned")

    // A new result is only loaded while the input is held off.
    `HPSD_CHECK_NOW(a_emit_idle, clk, rst_n, $rose(res_valid), !$past(pix_ready), "result loaded during frame load")

endmodule

bind heatmap_peak_subpixel_decode hpsd_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_valid(pixel.valid),
    .pix_ready(pixel.ready),
    .pix_last (pixel.last_pixel),
    .res_valid(result.valid),
    .res_ready(result.ready),
    .x_fixed  (result.x_fixed),
    .y_fixed  (result.y_fixed)
);
